### src/ddc_pkg.sv
// Shared constants and calendar functions for the date and day count converter.
package ddc_pkg;

   localparam int unsigned YEAR_W   = 12;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned COUNT_W  = 17;
   localparam int unsigned YLEN_W   = 9;

   localparam logic [YEAR_W-1:0]  FIRST_YEAR = 12'd1900;
   localparam logic [YEAR_W-1:0]  LAST_YEAR  = 12'd2100;
   localparam logic [COUNT_W-1:0] LAST_COUNT = 17'd73413;
   localparam logic [MONTH_W-1:0] FIRST_MONTH = 4'd1;
   localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;
   localparam logic [MONTH_W-1:0] FEBRUARY    = 4'd2;
   localparam logic [MONTH_W-1:0] APRIL       = 4'd4;
   localparam logic [MONTH_W-1:0] JUNE        = 4'd6;
   localparam logic [MONTH_W-1:0] SEPTEMBER   = 4'd9;
   localparam logic [MONTH_W-1:0] NOVEMBER    = 4'd11;

   typedef enum logic {
      OP_DATE_TO_COUNT = 1'b0,
      OP_COUNT_TO_DATE = 1'b1
   } opcode_type;

   // Valid for the supported span 1900..2100: only 1900 and 2100 are non-leap centuries.
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      is_leap = (year[1:0] == 2'b00) && (year != FIRST_YEAR) && (year != LAST_YEAR);
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0] year,
                                                  input logic [MONTH_W-1:0] month);
      if (month == FEBRUARY) begin
         month_len = is_leap(year) ? 5'd29 : 5'd28;
      end else if ((month == APRIL) || (month == JUNE) ||
                   (month == SEPTEMBER) || (month == NOVEMBER)) begin
         month_len = 5'd30;
      end else begin
         month_len = 5'd31;
      end
   endfunction

   function automatic logic [YLEN_W-1:0] year_len(input logic [YEAR_W-1:0] year);
      year_len = is_leap(year) ? 9'd366 : 9'd365;
   endfunction

endpackage

### src/date_day_count_converter.sv
// Gregorian date and day count converter, days counted from 1900-01-01.
// Date to count walks the months before the given one, then the years since 1900;
//   count to date walks whole years off the count, then whole months of the last year.
// A new request is taken only once the previous one has left the sequencer; both walks
//   share one add/subtract unit; a finished response may wait in its register meanwhile.
// Reset: synchronous, active high; clears the sequencer and the response valid flag.
module date_day_count_converter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic [ddc_pkg::YEAR_W-1:0]      req_year_in,
   input  logic [ddc_pkg::MONTH_W-1:0]     req_month_in,
   input  logic [ddc_pkg::DAY_W-1:0]       req_day_in,
   input  logic [ddc_pkg::COUNT_W-1:0]     req_count_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ddc_pkg::COUNT_W-1:0]     rsp_count_out,
   output logic [ddc_pkg::YEAR_W-1:0]      rsp_year_out,
   output logic [ddc_pkg::MONTH_W-1:0]     rsp_month_out,
   output logic [ddc_pkg::DAY_W-1:0]       rsp_day_out,
   output logic                            rsp_leap_year,
   output logic [ddc_pkg::DAY_W-1:0]       rsp_month_length,
   output logic                            rsp_out_of_range
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MONTH,
      ST_YEAR,
      ST_FINISH
   } state_type;

   state_type                          state_ff;
   logic                               opcode_ff;
   logic                               oor_ff;
   logic [ddc_pkg::YEAR_W-1:0]         year_ff;
   logic [ddc_pkg::MONTH_W-1:0]        month_ff;
   logic [ddc_pkg::DAY_W-1:0]          day_ff;
   logic [ddc_pkg::COUNT_W-1:0]        count_ff;
   logic [ddc_pkg::COUNT_W-1:0]        acc_ff;
   logic [ddc_pkg::YEAR_W-1:0]         yr_idx_ff;
   logic [ddc_pkg::MONTH_W-1:0]        mon_idx_ff;

   logic                               rsp_valid_ff;
   logic [ddc_pkg::COUNT_W-1:0]        rsp_count_ff;
   logic [ddc_pkg::YEAR_W-1:0]         rsp_year_ff;
   logic [ddc_pkg::MONTH_W-1:0]        rsp_month_ff;
   logic [ddc_pkg::DAY_W-1:0]          rsp_day_ff;
   logic                               rsp_leap_ff;
   logic [ddc_pkg::DAY_W-1:0]          rsp_mlen_ff;
   logic                               rsp_oor_ff;

   // Request-side saturation of an out-of-span date.
   logic [ddc_pkg::YEAR_W-1:0]         year_sat;
   logic [ddc_pkg::MONTH_W-1:0]        month_sat;
   logic [ddc_pkg::DAY_W-1:0]          day_lim;
   logic [ddc_pkg::DAY_W-1:0]          day_sat;
   logic                               date_oor;
   logic                               count_oor;
   logic                               req_fire;
   logic                               rsp_free;

   // Shared add/subtract unit.
   logic                               alu_sub;
   logic [ddc_pkg::YLEN_W-1:0]         alu_len;
   logic [ddc_pkg::COUNT_W-1:0]        alu_operand;
   logic [ddc_pkg::COUNT_W:0]          alu_sum;
   logic                               alu_fits;
   logic [ddc_pkg::COUNT_W-1:0]        alu_result;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Clamp year, then month, then day against the clamped month's length.
   always_comb begin
      year_sat  = req_year_in;
      month_sat = req_month_in;
      date_oor  = 1'b0;
      if (req_year_in < ddc_pkg::FIRST_YEAR) begin
         year_sat = ddc_pkg::FIRST_YEAR;
         date_oor = 1'b1;
      end else if (req_year_in > ddc_pkg::LAST_YEAR) begin
         year_sat = ddc_pkg::LAST_YEAR;
         date_oor = 1'b1;
      end
      if (req_month_in < ddc_pkg::FIRST_MONTH) begin
         month_sat = ddc_pkg::FIRST_MONTH;
         date_oor  = 1'b1;
      end else if (req_month_in > ddc_pkg::LAST_MONTH) begin
         month_sat = ddc_pkg::LAST_MONTH;
         date_oor  = 1'b1;
      end
      day_lim = ddc_pkg::month_len(year_sat, month_sat);
      day_sat = req_day_in;
      if (req_day_in == '0) begin
         day_sat  = 5'd1;
         date_oor = 1'b1;
      end else if (req_day_in > day_lim) begin
         day_sat  = day_lim;
         date_oor = 1'b1;
      end
   end

   assign count_oor = (req_count_in > ddc_pkg::LAST_COUNT);

   // Date mode accumulates lengths, count mode peels them off the remainder.
   // On a subtract, the carry out says the remainder covers the whole length.
   always_comb begin
      alu_sub = (opcode_ff == ddc_pkg::OP_COUNT_TO_DATE);
      if (state_ff == ST_YEAR) begin
         alu_len = ddc_pkg::year_len(yr_idx_ff);
      end else begin
         alu_len = {4'b0, ddc_pkg::month_len(year_ff, mon_idx_ff)};
      end
      alu_operand = {{(ddc_pkg::COUNT_W - ddc_pkg::YLEN_W){1'b0}}, alu_len};
      if (alu_sub) begin
         alu_operand = ~alu_operand;
      end
      alu_sum    = {1'b0, acc_ff} + {1'b0, alu_operand} +
                   {{ddc_pkg::COUNT_W{1'b0}}, alu_sub};
      alu_fits   = alu_sum[ddc_pkg::COUNT_W];
      alu_result = alu_sum[ddc_pkg::COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the response once it is taken, unless a new one is loaded now.
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  opcode_ff  <= req_opcode;
                  mon_idx_ff <= ddc_pkg::FIRST_MONTH;
                  yr_idx_ff  <= ddc_pkg::FIRST_YEAR;
                  if (req_opcode == ddc_pkg::OP_DATE_TO_COUNT) begin
                     year_ff  <= year_sat;
                     month_ff <= month_sat;
                     day_ff   <= day_sat;
                     oor_ff   <= date_oor;
                     acc_ff   <= {{(ddc_pkg::COUNT_W - ddc_pkg::DAY_W){1'b0}}, day_sat - 5'd1};
                     state_ff <= ST_MONTH;
                  end else begin
                     oor_ff   <= count_oor;
                     count_ff <= count_oor ? ddc_pkg::LAST_COUNT : req_count_in;
                     acc_ff   <= count_oor ? ddc_pkg::LAST_COUNT : req_count_in;
                     state_ff <= ST_YEAR;
                  end
               end
            end
            ST_MONTH: begin
               if (opcode_ff == ddc_pkg::OP_DATE_TO_COUNT) begin
                  // Add the lengths of the months before the given one.
                  if (mon_idx_ff == month_ff) begin
                     state_ff <= ST_YEAR;
                  end else begin
                     acc_ff     <= alu_result;
                     mon_idx_ff <= mon_idx_ff + 4'd1;
                  end
               end else begin
                  // Advance while the remainder spans the whole month.
                  if ((mon_idx_ff < ddc_pkg::LAST_MONTH) && alu_fits) begin
                     acc_ff     <= alu_result;
                     mon_idx_ff <= mon_idx_ff + 4'd1;
                  end else begin
                     month_ff <= mon_idx_ff;
                     day_ff   <= acc_ff[ddc_pkg::DAY_W-1:0] + 5'd1;
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_YEAR: begin
               if (opcode_ff == ddc_pkg::OP_DATE_TO_COUNT) begin
                  // Add the lengths of whole years since the epoch.
                  if (yr_idx_ff == year_ff) begin
                     count_ff <= acc_ff;
                     state_ff <= ST_FINISH;
                  end else begin
                     acc_ff    <= alu_result;
                     yr_idx_ff <= yr_idx_ff + 12'd1;
                  end
               end else begin
                  if ((yr_idx_ff < ddc_pkg::LAST_YEAR) && alu_fits) begin
                     acc_ff    <= alu_result;
                     yr_idx_ff <= yr_idx_ff + 12'd1;
                  end else begin
                     year_ff  <= yr_idx_ff;
                     state_ff <= ST_MONTH;
                  end
               end
            end
            ST_FINISH: begin
               // Hold until the response register is free.
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_count_ff <= count_ff;
                  rsp_year_ff  <= year_ff;
                  rsp_month_ff <= month_ff;
                  rsp_day_ff   <= day_ff;
                  rsp_leap_ff  <= ddc_pkg::is_leap(year_ff);
                  rsp_mlen_ff  <= ddc_pkg::month_len(year_ff, month_ff);
                  rsp_oor_ff   <= oor_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_count_out    = rsp_count_ff;
   assign rsp_year_out     = rsp_year_ff;
   assign rsp_month_out    = rsp_month_ff;
   assign rsp_day_out      = rsp_day_ff;
   assign rsp_leap_year    = rsp_leap_ff;
   assign rsp_month_length = rsp_mlen_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // A taken request leaves idle on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request taken but sequencer stayed idle");

   // The year walk never passes the last supported year.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_YEAR) |-> (yr_idx_ff <= ddc_pkg::LAST_YEAR))
      else $error("year index past the supported span");

   // A delivered day lies within its month.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_day_ff != '0) && (rsp_day_ff <= rsp_mlen_ff)))
      else $error("response day outside its month");

   // A delivered count never passes the last supported day.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff <= ddc_pkg::LAST_COUNT))
      else $error("response count past the supported span");

   // A new response is only loaded into a free register.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && !rsp_free) |=> (state_ff == ST_FINISH))
      else $error("finished result left while response register was full");

endmodule

### sim/tb_date_day_count_converter.sv
// Self-checking testbench for the date and day count converter.
module tb_date_day_count_converter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned YEAR_W  = ddc_pkg::YEAR_W;
   localparam int unsigned MONTH_W = ddc_pkg::MONTH_W;
   localparam int unsigned DAY_W   = ddc_pkg::DAY_W;
   localparam int unsigned COUNT_W = ddc_pkg::COUNT_W;
   localparam logic [YEAR_W-1:0]  FIRST_YEAR  = ddc_pkg::FIRST_YEAR;
   localparam logic [YEAR_W-1:0]  LAST_YEAR   = ddc_pkg::LAST_YEAR;
   localparam logic [COUNT_W-1:0] LAST_COUNT  = ddc_pkg::LAST_COUNT;
   localparam logic [MONTH_W-1:0] FIRST_MONTH = ddc_pkg::FIRST_MONTH;
   localparam logic [MONTH_W-1:0] LAST_MONTH  = ddc_pkg::LAST_MONTH;

   localparam int RANDOM_ITEMS    = 1500;
   localparam int CALM_ITEMS      = 150;   // closing stretch with no idling on either side
   localparam int DRAIN_CYCLES    = 240;   // a little more than the worst conversion latency
   localparam int WATCHDOG_LIMIT  = 4000;  // cycles without any handshake
   localparam int REPORT_LIMIT    = 10;
   localparam int N_DIRECTED      = 25;

   // One conversion request as it sits on the req_ ports.
   typedef struct packed {
      ddc_pkg::opcode_type op;
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [COUNT_W-1:0]  count;
   } date_request_type;

   // One conversion response as it sits on the rsp_ ports.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic               leap;
      logic [DAY_W-1:0]   mlen;
      logic               oor;
   } date_result_type;

   // Directed row: the request, and a hand-written response where typed is set.
   typedef struct packed {
      date_request_type req;
      logic             typed;
      date_result_type  res;
   } directed_row_type;

   // Boundary dates, saturation of bad fields, leap and century rules.
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // first and last supported dates in both directions
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd1900, 4'd1, 5'd1, 17'd0}, 1'b1,
        '{17'd0, 12'd1900, 4'd1, 5'd1, 1'b0, 5'd31, 1'b0}},
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd2100, 4'd12, 5'd31, 17'h1FFFF}, 1'b1,
        '{17'd73413, 12'd2100, 4'd12, 5'd31, 1'b0, 5'd31, 1'b0}},
      '{'{ddc_pkg::OP_COUNT_TO_DATE, 12'hFFF, 4'hF, 5'h1F, 17'd0}, 1'b1,
        '{17'd0, 12'd1900, 4'd1, 5'd1, 1'b0, 5'd31, 1'b0}},
      '{'{ddc_pkg::OP_COUNT_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd73413}, 1'b1,
        '{17'd73413, 12'd2100, 4'd12, 5'd31, 1'b0, 5'd31, 1'b0}},
      // counts past the last date clamp and flag
      '{'{ddc_pkg::OP_COUNT_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd73414}, 1'b1,
        '{17'd73413, 12'd2100, 4'd12, 5'd31, 1'b0, 5'd31, 1'b1}},
      '{'{ddc_pkg::OP_COUNT_TO_DATE, 12'hFFF, 4'hF, 5'h1F, 17'h1FFFF}, 1'b1,
        '{17'd73413, 12'd2100, 4'd12, 5'd31, 1'b0, 5'd31, 1'b1}},
      // all-zero and all-ones date fields saturate
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd0, 4'd0, 5'd0, 17'd0}, 1'b1,
        '{17'd0, 12'd1900, 4'd1, 5'd1, 1'b0, 5'd31, 1'b1}},
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'hFFF, 4'hF, 5'h1F, 17'h1FFFF}, 1'b1,
        '{17'd73413, 12'd2100, 4'd12, 5'd31, 1'b0, 5'd31, 1'b1}},
      // 1900 is a century without a leap day; out-of-span years and months clamp and flag
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd1900, 4'd2, 5'd29, 17'd0}, 1'b1,
        '{17'd58, 12'd1900, 4'd2, 5'd28, 1'b0, 5'd28, 1'b1}},
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd1899, 4'd1, 5'd1, 17'd0}, 1'b1,
        '{17'd0, 12'd1900, 4'd1, 5'd1, 1'b0, 5'd31, 1'b1}},
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd2101, 4'd12, 5'd31, 17'd0}, 1'b1,
        '{17'd73413, 12'd2100, 4'd12, 5'd31, 1'b0, 5'd31, 1'b1}},
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd1900, 4'd13, 5'd1, 17'd0}, 1'b1,
        '{17'd334, 12'd1900, 4'd12, 5'd1, 1'b0, 5'd31, 1'b1}},
      // leap days, month ends and year boundaries, checked by the predictor
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd2000, 4'd2, 5'd29, 17'h1FFFF}, 1'b0, '0},
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd2000, 4'd2, 5'd30, 17'd0}, 1'b0, '0},
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd2100, 4'd2, 5'd29, 17'd0}, 1'b0, '0},
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd1999, 4'd12, 5'd31, 17'h0AAAA}, 1'b0, '0},
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd2000, 4'd1, 5'd1, 17'h15555}, 1'b0, '0},
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd2096, 4'd2, 5'd29, 17'd0}, 1'b0, '0},
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd1950, 4'd4, 5'd31, 17'd0}, 1'b0, '0},
      '{'{ddc_pkg::OP_DATE_TO_COUNT, 12'd1900, 4'd1, 5'd0, 17'd0}, 1'b0, '0},
      '{'{ddc_pkg::OP_COUNT_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd58}, 1'b0, '0},
      '{'{ddc_pkg::OP_COUNT_TO_DATE, 12'h555, 4'h5, 5'h15, 17'd59}, 1'b0, '0},
      '{'{ddc_pkg::OP_COUNT_TO_DATE, 12'hAAA, 4'hA, 5'h0A, 17'd36583}, 1'b0, '0},
      '{'{ddc_pkg::OP_COUNT_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd73048}, 1'b0, '0},
      '{'{ddc_pkg::OP_COUNT_TO_DATE, 12'd0, 4'd0, 5'd0, 17'd73049}, 1'b0, '0}
   };

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_opcode;
   logic [YEAR_W-1:0]  req_year_in;
   logic [MONTH_W-1:0] req_month_in;
   logic [DAY_W-1:0]   req_day_in;
   logic [COUNT_W-1:0] req_count_in;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [COUNT_W-1:0] rsp_count_out;
   logic [YEAR_W-1:0]  rsp_year_out;
   logic [MONTH_W-1:0] rsp_month_out;
   logic [DAY_W-1:0]   rsp_day_out;
   logic               rsp_leap_year;
   logic [DAY_W-1:0]   rsp_month_length;
   logic               rsp_out_of_range;

   date_result_type predicted_conversions [$];
   int              mismatch_count = 0;
   int              quiet_cycles   = 0;
   int              req_gap_pct    = 15;
   int              rsp_stall_pct  = 15;
   int              rsp_stall_left = 0;
   bit              calm           = 1'b0;

   // Hand-written response for the request now on the ports, if any.
   logic            cur_typed;
   date_result_type cur_typed_res;

   date_day_count_converter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_year_in      (req_year_in),
      .req_month_in     (req_month_in),
      .req_day_in       (req_day_in),
      .req_count_in     (req_count_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_count_out    (rsp_count_out),
      .rsp_year_out     (rsp_year_out),
      .rsp_month_out    (rsp_month_out),
      .rsp_day_out      (rsp_day_out),
      .rsp_leap_year    (rsp_leap_year),
      .rsp_month_length (rsp_month_length),
      .rsp_out_of_range (rsp_out_of_range)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Full Gregorian rule, independent of the span the block supports.
   function automatic bit gregorian_leap(input int unsigned year);
      return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
   endfunction

   function automatic int unsigned days_in_month(input int unsigned year,
                                                 input int unsigned month);
      case (month)
         2:          return gregorian_leap(year) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:    return 31;
      endcase
   endfunction

   function automatic int unsigned days_in_year(input int unsigned year);
      return gregorian_leap(year) ? 366 : 365;
   endfunction

   // Predict the response for one request.
   function automatic date_result_type convert_date(input date_request_type rq);
      date_result_type res;
      int unsigned     y;
      int unsigned     m;
      int unsigned     d;
      int unsigned     cnt;
      int unsigned     rem;
      int unsigned     i;
      logic            oor;
      oor = 1'b0;
      if (rq.op == ddc_pkg::OP_DATE_TO_COUNT) begin
         y = rq.year;
         m = rq.month;
         d = rq.day;
         // clamp each field into the supported calendar and flag it
         if (y < FIRST_YEAR) begin
            y   = FIRST_YEAR;
            oor = 1'b1;
         end
         if (y > LAST_YEAR) begin
            y   = LAST_YEAR;
            oor = 1'b1;
         end
         if (m < FIRST_MONTH) begin
            m   = FIRST_MONTH;
            oor = 1'b1;
         end
         if (m > LAST_MONTH) begin
            m   = LAST_MONTH;
            oor = 1'b1;
         end
         if (d < 1) begin
            d   = 1;
            oor = 1'b1;
         end
         if (d > days_in_month(y, m)) begin
            d   = days_in_month(y, m);
            oor = 1'b1;
         end
         cnt = d - 1;
         for (i = FIRST_MONTH; i < m; i++) cnt += days_in_month(y, i);
         for (i = FIRST_YEAR; i < y; i++) cnt += days_in_year(i);
      end else begin
         cnt = rq.count;
         if (cnt > LAST_COUNT) begin
            cnt = LAST_COUNT;
            oor = 1'b1;
         end
         rem = cnt;
         y   = FIRST_YEAR;
         while ((y < LAST_YEAR) && (rem >= days_in_year(y))) begin
            rem -= days_in_year(y);
            y++;
         end
         m = FIRST_MONTH;
         while ((m < LAST_MONTH) && (rem >= days_in_month(y, m))) begin
            rem -= days_in_month(y, m);
            m++;
         end
         d = rem + 1;
      end
      res.count = COUNT_W'(cnt);
      res.year  = YEAR_W'(y);
      res.month = MONTH_W'(m);
      res.day   = DAY_W'(d);
      res.leap  = gregorian_leap(y);
      res.mlen  = DAY_W'(days_in_month(y, m));
      res.oor   = oor;
      return res;
   endfunction

   // Mostly well-formed requests; the rest carry bad months, days, years or counts.
   function automatic date_request_type random_request();
      date_request_type rq;
      int               kind;
      rq.op    = ddc_pkg::opcode_type'(1'($urandom_range(0, 1)));
      rq.year  = YEAR_W'($urandom);
      rq.month = MONTH_W'($urandom);
      rq.day   = DAY_W'($urandom);
      rq.count = COUNT_W'($urandom);
      kind     = $urandom_range(0, 99);
      if (rq.op == ddc_pkg::OP_DATE_TO_COUNT) begin
         if (kind < 90) rq.year = YEAR_W'($urandom_range(FIRST_YEAR, LAST_YEAR));
         if (kind < 80) begin
            rq.month = MONTH_W'($urandom_range(FIRST_MONTH, LAST_MONTH));
            rq.day   = DAY_W'($urandom_range(1, days_in_month(rq.year, rq.month)));
         end
      end else if (kind < 90) begin
         rq.count = COUNT_W'($urandom_range(0, LAST_COUNT));
      end
      return rq;
   endfunction

   // Present one request and hold it until accepted; entered and left at a falling edge.
   task automatic send_request(input date_request_type rq, input logic typed,
                               input date_result_type typed_res);
      if (!calm && ($urandom_range(0, 99) < req_gap_pct)) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= rq.op;
      req_year_in   <= rq.year;
      req_month_in  <= rq.month;
      req_day_in    <= rq.day;
      req_count_in  <= rq.count;
      cur_typed     <= typed;
      cur_typed_res <= typed_res;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
   endtask

   // Response side: stall in random bursts of random length, never in the calm stretch.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (!calm && (rsp_stall_left > 0)) begin
            rsp_ready <= 1'b0;
            rsp_stall_left--;
         end else if (!calm && ($urandom_range(0, 99) < rsp_stall_pct)) begin
            rsp_ready      <= 1'b0;
            rsp_stall_left = $urandom_range(0, 6);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on each accepted request, compare on each accepted response.
   always @(posedge clock) begin
      date_request_type rq;
      date_result_type  got;
      date_result_type  want;
      bit               moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            rq.op    = ddc_pkg::opcode_type'(req_opcode);
            rq.year  = req_year_in;
            rq.month = req_month_in;
            rq.day   = req_day_in;
            rq.count = req_count_in;
            predicted_conversions.push_back(cur_typed ? cur_typed_res : convert_date(rq));
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_count_out, rsp_year_out, rsp_month_out, rsp_day_out,
                    rsp_leap_year, rsp_month_length, rsp_out_of_range};
            moved = 1'b1;
            if (predicted_conversions.size() == 0) begin
               // response with no request waiting on it
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected response: count=%0d date=%0d-%0d-%0d",
                           got.count, got.year, got.month, got.day);
            end else begin
               want = predicted_conversions.pop_front();
               if ((got.count !== want.count) || (got.year !== want.year) ||
                   (got.month !== want.month) || (got.day !== want.day) ||
                   (got.leap !== want.leap) || (got.mlen !== want.mlen) ||
                   (got.oor !== want.oor)) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display({"mismatch: expected count=%0d date=%0d-%0d-%0d",
                               " leap=%0d len=%0d oor=%0d"},
                              want.count, want.year, want.month, want.day,
                              want.leap, want.mlen, want.oor);
                     $display({"          actual   count=%0d date=%0d-%0d-%0d",
                               " leap=%0d len=%0d oor=%0d"},
                              got.count, got.year, got.month, got.day,
                              got.leap, got.mlen, got.oor);
                  end
               end
            end
         end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
   end

   // Watchdog: stop a run in which no handshake happens for too long.
   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("date_day_count_converter regression: fail");
      $finish;
   end

   // Main sequence: reset, directed table, random requests, drain.
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = ddc_pkg::OP_DATE_TO_COUNT;
      req_year_in   = '0;
      req_month_in  = '0;
      req_day_in    = '0;
      req_count_in  = '0;
      cur_typed     = 1'b0;
      cur_typed_res = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIRECTED; r++)
         send_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // reshuffle the idling mix every hundred requests, quiet stretches included
         if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0:       req_gap_pct = 0;
               1:       req_gap_pct = 15;
               default: req_gap_pct = 50;
            endcase
            case ($urandom_range(0, 2))
               0:       rsp_stall_pct = 0;
               1:       rsp_stall_pct = 15;
               default: rsp_stall_pct = 50;
            endcase
         end
         calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
         send_request(random_request(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      // drain outstanding responses, then watch for strays
      while (predicted_conversions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && predicted_conversions.size() == 0) begin
         $display("date_day_count_converter regression: pass");
      end else begin
         $display("date_day_count_converter regression: fail");
      end
      $finish;
   end

endmodule
